// File: rtl/core/chr_pkg.sv
// ============================================================================
// chr_pkg - shared constants and helpers for the consistent hash ring
// Holds table sizes, index widths, request kind codes and the FNV-1a 64 step.
// ============================================================================
package chr_pkg;

  // Table sizes
  localparam int MAX_NODES           = 16;
  localparam int MAX_VNODES_PER_NODE = 64;
  localparam int VCAP                = MAX_NODES * MAX_VNODES_PER_NODE;
  localparam int MAX_OUT             = 16;

  // Index and count widths
  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int NCNT_W = NIDX_W + 1;
  localparam int VIDX_W = $clog2(VCAP);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int OIDX_W = $clog2(MAX_OUT);
  localparam int OCNT_W = OIDX_W + 1;

  // Request kinds
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_KEY    = 3'd3;
  localparam logic [2:0] KIND_QUERY  = 3'd4;

  // FNV-1a 64
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // Prime is 2^40 + 0x1B3: one shift plus a small constant product
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * 64'd435);
  endfunction

  // Clamp a requested weight to 1..MAX_VNODES_PER_NODE
  function automatic logic [6:0] clamp_weight(input logic [6:0] w);
    if (w == 7'd0) return 7'd1;
    if (w > 7'(MAX_VNODES_PER_NODE)) return 7'(MAX_VNODES_PER_NODE);
    return w;
  endfunction

  // Clamp a replica count to MAX_OUT
  function automatic logic [4:0] clamp_want(input logic [4:0] r);
    if (r > 5'(MAX_OUT)) return 5'(MAX_OUT);
    return r;
  endfunction

endpackage

// File: rtl/core/consistent_hash_ring.sv
// ============================================================================
// consistent_hash_ring - weighted consistent hash ring with FNV-1a 64
// Node table, sorted virtual-node memory, key hashing and owner lookup.
// ============================================================================
// Usage:
//   Slave channel s_*: one request per transfer. s_tuser is the kind (add,
//   set weight, remove, key byte, weight query), s_tlast marks the last key
//   byte. Master channel m_*: result transfers; m_tlast marks the final
//   result of a request, m_tuser says the result carries an owner.
//   Non-final key bytes give no result; unused kinds are
//   dropped. Every other request gives one result, a lookup one to sixteen.
//   Flow: the node table is searched one entry a cycle until the id or
//   the end of the table is seen.
//   Each virtual node placed is hashed over twelve bytes, then each ring
//   entry above its slot is shifted up (single-port read/modify/write of
//   the ring memory); a remove or weight change sweeps the ring entry by
//   entry.
//   A lookup runs a binary search (up to 11 steps), then walks the ring
//   entry by entry, then sends one result a cycle while the receiver is ready.
//   One request is worked on at a time; s_tready is high only when idle.
//   A stalled receiver holds the result register; the block waits for it.
//   Reset empties both tables and restarts the key hash; no clearing pass.
// ============================================================================
module consistent_hash_ring (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // node_id[31:0], weight[38:32], key_byte[46:39], replicas[51:47]
  input  logic [55:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], owner_node[32:1], owner_rank[36:33], node_weight[43:37],
  // nodes_present[48:44]
  output logic [55:0] m_tdata,
  // owner_valid[0]
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int VW = chr_pkg::VIDX_W;
  localparam int VC = chr_pkg::VCNT_W;
  localparam int NC = chr_pkg::NCNT_W;
  localparam int NI = chr_pkg::NIDX_W;
  localparam int OC = chr_pkg::OCNT_W;
  localparam int OI = chr_pkg::OIDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_REM_COPY, S_DROP_RD, S_DROP_CHK, S_HASH, S_INS_RD,
    S_INS_CMP, S_VNEXT, S_LK_START, S_BS_RD, S_BS_CMP, S_WK_RD, S_WK_CHK,
    S_EMIT, S_RESP
  } state_t;

  state_t state;

  // Request registers
  logic [2:0]  op_kind;
  logic [31:0] op_id;
  logic [6:0]  op_w;
  logic [4:0]  op_want;
  logic        op_status;
  logic [6:0]  op_qw;

  // Node table
  logic [31:0] nt_id [chr_pkg::MAX_NODES];
  logic [6:0]  nt_w  [chr_pkg::MAX_NODES];
  logic [NC-1:0] node_total;
  logic [NC-1:0] nscan;
  logic [NI-1:0] fidx;
  logic [NC-1:0] nt_end;

  // Ring memory: {owner, position}
  logic [95:0]   vmem [chr_pkg::VCAP];
  logic [95:0]   mem_rdata;
  logic [95:0]   mem_wdata;
  logic [VW-1:0] mem_raddr;
  logic [VW-1:0] mem_waddr;
  logic          mem_we;
  logic [63:0]   rd_pos;
  logic [31:0]   rd_owner;
  logic [VC-1:0] vnode_total;

  // Hashing
  logic [63:0] key_hash;
  logic [63:0] look_hash;
  logic [63:0] key_mixed;
  logic [63:0] vh;
  logic [3:0]  bcnt;
  logic [6:0]  vcnt;
  logic [7:0]  vbyte;

  // Ring pointers
  logic [VC-1:0] ii;
  logic [VC-1:0] ii_m1;
  logic [VC-1:0] rptr;
  logic [VC-1:0] wptr;
  logic [VC-1:0] lo;
  logic [VC-1:0] hi;
  logic [VC-1:0] mid;
  logic [VC-1:0] mid_c;
  logic [VC-1:0] at;
  logic [VC-1:0] at_inc;
  logic [VC-1:0] step;

  // Owners found
  logic [31:0]   got [chr_pkg::MAX_OUT];
  logic [OC-1:0] found;
  logic [OC-1:0] eidx;
  logic          dup;
  logic          out_free;
  logic          out_load;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == S_EMIT || state == S_RESP) && out_free;
  assign rd_pos    = mem_rdata[63:0];
  assign rd_owner  = mem_rdata[95:64];
  assign nt_end    = node_total - NC'(1);
  assign ii_m1     = ii - VC'(1);
  assign mid_c     = lo + ((hi - lo) >> 1);
  assign at_inc    = at + VC'(1);
  assign key_mixed = chr_pkg::fnv_mix(key_hash, s_tdata[46:39]);

  // Select the next byte of the virtual node hash input
  always_comb begin
    unique case (bcnt)
      4'd0:    vbyte = op_id[7:0];
      4'd1:    vbyte = op_id[15:8];
      4'd2:    vbyte = op_id[23:16];
      4'd3:    vbyte = op_id[31:24];
      4'd8:    vbyte = {1'b0, vcnt};
      default: vbyte = 8'd0;
    endcase
  end

  // Check the walked owner against owners already found
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < chr_pkg::MAX_OUT; j++) begin
      if ((OC'(j) < found) && (got[j] == rd_owner)) dup = 1'b1;
    end
  end

  // Drive ring memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_raddr = '0;
    mem_waddr = '0;
    mem_wdata = {op_id, vh};
    unique case (state)
      S_INS_RD: begin
        mem_raddr = ii_m1[VW-1:0];
        if (ii == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
        end
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = ii[VW-1:0];
        if (rd_pos > vh) mem_wdata = mem_rdata;
      end
      S_DROP_RD: mem_raddr = rptr[VW-1:0];
      S_DROP_CHK: begin
        mem_we    = (rd_owner != op_id);
        mem_waddr = wptr[VW-1:0];
        mem_wdata = mem_rdata;
      end
      S_BS_RD: mem_raddr = mid_c[VW-1:0];
      S_WK_RD: mem_raddr = at[VW-1:0];
      default: mem_raddr = '0;
    endcase
  end

  // Ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) vmem[mem_waddr] <= mem_wdata;
    mem_rdata <= vmem[mem_raddr];
  end

  // Control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      node_total  <= '0;
      vnode_total <= '0;
      key_hash    <= chr_pkg::FNV_BASIS;
    end else begin
      if (m_tready && !out_load) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_kind   <= s_tuser;
            op_id     <= s_tdata[31:0];
            op_w      <= chr_pkg::clamp_weight(s_tdata[38:32]);
            op_status <= 1'b0;
            op_qw     <= 7'd0;
            nscan     <= '0;
            priority if (s_tuser == chr_pkg::KIND_KEY) begin
              if (s_tlast) begin
                look_hash <= key_mixed;
                key_hash  <= chr_pkg::FNV_BASIS;
                op_want   <= chr_pkg::clamp_want(s_tdata[51:47]);
                state     <= S_LK_START;
              end else begin
                key_hash <= key_mixed;
              end
            end else if (s_tuser == chr_pkg::KIND_ADD || s_tuser == chr_pkg::KIND_SET ||
                         s_tuser == chr_pkg::KIND_REMOVE ||
                         s_tuser == chr_pkg::KIND_QUERY) begin
              state <= S_FIND;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        // Scan the node table one entry a cycle
        S_FIND: begin
          priority if (nscan == node_total) begin
            if (op_kind == chr_pkg::KIND_ADD || op_kind == chr_pkg::KIND_SET) begin
              if (node_total == NC'(chr_pkg::MAX_NODES)) begin
                op_status <= 1'b1;
                state     <= S_RESP;
              end else begin
                nt_id[node_total[NI-1:0]] <= op_id;
                nt_w[node_total[NI-1:0]]  <= op_w;
                node_total <= node_total + NC'(1);
                vcnt  <= '0;
                vh    <= chr_pkg::FNV_BASIS;
                bcnt  <= '0;
                state <= S_HASH;
              end
            end else begin
              state <= S_RESP;
            end
          end else if (nt_id[nscan[NI-1:0]] == op_id) begin
            fidx <= nscan[NI-1:0];
            rptr <= '0;
            wptr <= '0;
            priority if (op_kind == chr_pkg::KIND_SET) begin
              if (nt_w[nscan[NI-1:0]] != op_w) begin
                nt_w[nscan[NI-1:0]] <= op_w;
                state <= S_DROP_RD;
              end else begin
                state <= S_RESP;
              end
            end else if (op_kind == chr_pkg::KIND_REMOVE) begin
              state <= S_REM_COPY;
            end else if (op_kind == chr_pkg::KIND_QUERY) begin
              op_qw <= nt_w[nscan[NI-1:0]];
              state <= S_RESP;
            end else begin
              state <= S_RESP;
            end
          end else begin
            nscan <= nscan + NC'(1);
          end
        end

        // Move the last table entry into the freed slot
        S_REM_COPY: begin
          nt_id[fidx] <= nt_id[nt_end[NI-1:0]];
          nt_w[fidx]  <= nt_w[nt_end[NI-1:0]];
          node_total  <= nt_end;
          state       <= S_DROP_RD;
        end

        // Compact the ring, dropping entries of the node
        S_DROP_RD: begin
          if (rptr == vnode_total) begin
            vnode_total <= wptr;
            if (op_kind == chr_pkg::KIND_SET) begin
              vcnt  <= '0;
              vh    <= chr_pkg::FNV_BASIS;
              bcnt  <= '0;
              state <= S_HASH;
            end else begin
              state <= S_RESP;
            end
          end else begin
            state <= S_DROP_CHK;
          end
        end
        S_DROP_CHK: begin
          if (rd_owner != op_id) wptr <= wptr + VC'(1);
          rptr  <= rptr + VC'(1);
          state <= S_DROP_RD;
        end

        // Hash twelve bytes of the virtual node, one per cycle
        S_HASH: begin
          vh   <= chr_pkg::fnv_mix(vh, vbyte);
          bcnt <= bcnt + 4'd1;
          if (bcnt == 4'd11) begin
            ii    <= vnode_total;
            state <= (vnode_total >= VC'(chr_pkg::VCAP)) ? S_VNEXT : S_INS_RD;
          end
        end

        // Shift larger entries up and drop the new one in place
        S_INS_RD: begin
          if (ii == '0) begin
            vnode_total <= vnode_total + VC'(1);
            state       <= S_VNEXT;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_pos > vh) begin
            ii    <= ii_m1;
            state <= S_INS_RD;
          end else begin
            vnode_total <= vnode_total + VC'(1);
            state       <= S_VNEXT;
          end
        end
        S_VNEXT: begin
          if (vcnt + 7'd1 == op_w) begin
            state <= S_RESP;
          end else begin
            vcnt  <= vcnt + 7'd1;
            vh    <= chr_pkg::FNV_BASIS;
            bcnt  <= '0;
            state <= S_HASH;
          end
        end

        // Lookup: binary search for the first position at or above the hash
        S_LK_START: begin
          found <= '0;
          if (op_want == 5'd0 || vnode_total == '0) begin
            state <= S_EMIT;
          end else begin
            lo    <= '0;
            hi    <= vnode_total;
            state <= S_BS_RD;
          end
        end
        S_BS_RD: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_BS_CMP;
          end else begin
            at    <= (lo >= vnode_total) ? '0 : lo;
            step  <= '0;
            state <= S_WK_RD;
          end
        end
        S_BS_CMP: begin
          if (rd_pos < look_hash) lo <= mid + VC'(1);
          else hi <= mid;
          state <= S_BS_RD;
        end

        // Walk the ring collecting distinct owners
        S_WK_RD: begin
          if (step < vnode_total && OC'(op_want) > found && NC'(found) < node_total) begin
            state <= S_WK_CHK;
          end else begin
            eidx  <= '0;
            state <= S_EMIT;
          end
        end
        S_WK_CHK: begin
          if (!dup) begin
            got[found[OI-1:0]] <= rd_owner;
            found <= found + OC'(1);
          end
          step  <= step + VC'(1);
          at    <= (at_inc == vnode_total) ? '0 : at_inc;
          state <= S_WK_RD;
        end

        // Send owners one transfer each, or one ownerless result if none were found
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (found == '0) begin
              m_tdata <= {7'd0, node_total, 7'd0, 4'd0, 32'd0, 1'b0};
              m_tuser <= 1'b0;
              m_tlast <= 1'b1;
              state   <= S_IDLE;
            end else begin
              m_tdata <= {7'd0, node_total, 7'd0, eidx[OI-1:0], got[eidx[OI-1:0]], 1'b0};
              m_tuser <= 1'b1;
              m_tlast <= (eidx + OC'(1) == found);
              eidx    <= eidx + OC'(1);
              if (eidx + OC'(1) == found) state <= S_IDLE;
            end
          end
        end

        // Send the single result of a table request
        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, node_total, op_qw, 4'd0, 32'd0, op_status};
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_vnode_bound: assert property (@(posedge clk) disable iff (rst)
    vnode_total <= VC'(chr_pkg::VCAP))
    else $error("ring count above capacity");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_total <= NC'(chr_pkg::MAX_NODES))
    else $error("node count above table size");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && node_total == '0) |-> vnode_total == '0)
    else $error("ring entries left with no nodes");

  a_miss_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("ownerless result not final");

endmodule
